/* rtl/dfif_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dfif_pkg
// Types and constants shared by the direct-form filter modules.
// ---------------------------------------------------------------------------
package dfif_pkg;

    localparam int SAMPLE_W = 16;
    localparam int COEF_W   = 16;
    localparam int PROD_W   = 32;
    localparam int ACC_W    = 40;
    localparam int FRAC_W   = 14;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;

    localparam logic [CFG_IDX_W-1:0] REG_FORWARD_TAPS  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK_TAPS = 1'b1;

    localparam logic [4:0] FORWARD_TAPS_RESET  = 5'd1;
    localparam logic [3:0] FEEDBACK_TAPS_RESET = 4'd0;

    typedef enum logic [1:0] {
        ACT_SAMPLE   = 2'd0,
        ACT_LOAD_FWD = 2'd1,
        ACT_LOAD_FB  = 2'd2,
        ACT_CLEAR    = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FWD,
        S_FB,
        S_DRAIN,
        S_DONE
    } t_state;

    typedef struct packed {
        t_action                    action;
        logic [3:0]                 tap_index;
        logic signed [SAMPLE_W-1:0] sample_in;
        logic signed [COEF_W-1:0]   coefficient;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_out;
        logic                       saturated;
    } t_out_item;

endpackage

/* rtl/dfif_ram.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dfif_ram
// Single write, single read store with registered read and per-entry
// valid bits; an entry never written since reset or clear reads as zero.
// ---------------------------------------------------------------------------
module dfif_ram import dfif_pkg::*; #(
    parameter int DEPTH = 16,
    parameter int AW    = $clog2((DEPTH > 1) ? DEPTH : 2)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_clr,
    input  logic                       i_we,
    input  logic [AW-1:0]              i_waddr,
    input  logic signed [COEF_W-1:0]   i_wdata,
    input  logic [AW-1:0]              i_raddr,
    output logic signed [COEF_W-1:0]   o_rdata
);

    logic signed [COEF_W-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0]         r_vld;
    logic signed [COEF_W-1:0] r_raw;
    logic                     r_rv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clr) begin
            r_vld <= '0;
        end else if (i_we) begin
            r_vld[i_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_raw <= r_mem[i_raddr];
        r_rv  <= r_vld[i_raddr];
    end

    assign o_rdata = r_rv ? r_raw : '0;

endmodule

/* rtl/dfif_mac.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dfif_mac
// Shared multiply-accumulate unit: registered product, then 40-bit
// accumulate into a registered accumulator.
// ---------------------------------------------------------------------------
module dfif_mac import dfif_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_clr,
    input  logic                      i_valid,
    input  logic signed [COEF_W-1:0]  i_a,
    input  logic signed [SAMPLE_W-1:0] i_b,
    output logic signed [ACC_W-1:0]   o_acc
);

    logic signed [PROD_W-1:0] r_prod;
    logic                     r_pv;
    logic signed [ACC_W-1:0]  r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else begin
            r_pv <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(i_a * i_b);
        if (i_clr) begin
            r_acc <= '0;
        end else if (r_pv) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
    end

    assign o_acc = r_acc;

endmodule

/* rtl/dfif_round.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dfif_round
// Round half up, shift right by the fraction width and saturate the
// accumulator to a signed 16-bit sample with a saturation flag.
// ---------------------------------------------------------------------------
module dfif_round import dfif_pkg::*; (
    input  logic signed [ACC_W-1:0] i_acc,
    output t_out_item               o_item
);

    localparam logic signed [ACC_W-1:0] HALF    = ACC_W'(1) <<< (FRAC_W - 1);
    localparam logic signed [ACC_W-1:0] MAX_OUT = ACC_W'(32767);
    localparam logic signed [ACC_W-1:0] MIN_OUT = -ACC_W'(32768);

    logic signed [ACC_W-1:0] w_sum;
    logic signed [ACC_W-1:0] w_shr;

    always_comb begin
        w_sum = i_acc + HALF;
        w_shr = w_sum >>> FRAC_W;
        if (w_shr > MAX_OUT) begin
            o_item.sample_out = 16'sh7fff;
            o_item.saturated  = 1'b1;
        end else if (w_shr < MIN_OUT) begin
            o_item.sample_out = 16'sh8000;
            o_item.saturated  = 1'b1;
        end else begin
            o_item.sample_out = w_shr[SAMPLE_W-1:0];
            o_item.saturated  = 1'b0;
        end
    end

endmodule

/* rtl/direct_form_iir_fir_filter.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// direct_form_iir_fir_filter
// Direct-form filter with Q2.14 coefficients and 16-bit samples.
// ---------------------------------------------------------------------------
// A sample item runs from acceptance to a ready result as follows, where nf
// is the feedforward tap count in use and nb the feedback tap count in use:
// one multiply-accumulate unit walks the nf and then the nb taps one per
// cycle, then S_DRAIN drains its pipeline and S_DONE registers the rounded
// result. Load and clear items leave input ready high. Input ready is low
// while a sample is being worked; a finished result waits in the output
// register, and the next sample holds in S_DONE until that register is taken.
module direct_form_iir_fir_filter import dfif_pkg::*; #(
    parameter int MAX_FORWARD_TAPS  = 16,
    parameter int MAX_FEEDBACK_TAPS = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_item,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int FA_W   = $clog2((MAX_FORWARD_TAPS > 1) ? MAX_FORWARD_TAPS : 2);
    localparam int BA_W   = $clog2((MAX_FEEDBACK_TAPS > 1) ? MAX_FEEDBACK_TAPS : 2);
    localparam int MAXT   = (MAX_FORWARD_TAPS > MAX_FEEDBACK_TAPS) ?
                            MAX_FORWARD_TAPS : MAX_FEEDBACK_TAPS;
    localparam int CNT_W  = $clog2((MAXT > 1) ? MAXT : 2);

    t_state                   r_state, n_state;
    logic [4:0]               r_fwd_taps;
    logic [3:0]               r_fb_taps;
    logic [CNT_W-1:0]         r_cnt, n_cnt;
    logic [FA_W-1:0]          r_fhead, n_fhead, r_fh, n_fh;
    logic [BA_W-1:0]          r_bhead, n_bhead, r_bh, n_bh;
    logic                     r_out_valid, n_out_valid;
    t_out_item                r_out, n_out;
    logic                     r_iss_d, r_sel_d;

    logic [7:0]               w_nf8, w_nb8;
    logic [CNT_W-1:0]         w_f_last, w_b_last;
    logic                     w_fb_on;
    logic                     w_accept;
    logic [FA_W-1:0]          w_fhead_dec, w_fh_inc;
    logic [BA_W-1:0]          w_bhead_dec, w_bh_inc;
    logic                     w_iss, w_sel_fb, w_mac_clr, w_hist_clr;
    logic                     w_fc_we, w_bc_we, w_fi_we, w_bo_we;
    logic signed [COEF_W-1:0] w_fc_rd, w_bc_rd, w_fi_rd, w_bo_rd;
    logic signed [ACC_W-1:0]  w_acc;
    t_out_item                w_round;

    // taps in use
    always_comb begin
        w_nf8 = {3'b000, r_fwd_taps};
        if (w_nf8 == 8'd0) begin
            w_nf8 = 8'd1;
        end
        if (w_nf8 > 8'(MAX_FORWARD_TAPS)) begin
            w_nf8 = 8'(MAX_FORWARD_TAPS);
        end
        w_nb8 = {4'b0000, r_fb_taps};
        if (w_nb8 > 8'(MAX_FEEDBACK_TAPS)) begin
            w_nb8 = 8'(MAX_FEEDBACK_TAPS);
        end
        w_f_last = CNT_W'(w_nf8 - 8'd1);
        w_b_last = CNT_W'(w_nb8 - 8'd1);
        w_fb_on  = (w_nb8 != 8'd0);
    end

    assign w_fhead_dec = (r_fhead == '0) ? FA_W'(MAX_FORWARD_TAPS - 1) : r_fhead - 1'b1;
    assign w_fh_inc    = (r_fh == FA_W'(MAX_FORWARD_TAPS - 1)) ? '0 : r_fh + 1'b1;
    assign w_bhead_dec = (r_bhead == '0) ? BA_W'(MAX_FEEDBACK_TAPS - 1) : r_bhead - 1'b1;
    assign w_bh_inc    = (r_bh == BA_W'(MAX_FEEDBACK_TAPS - 1)) ? '0 : r_bh + 1'b1;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_taps <= FORWARD_TAPS_RESET;
            r_fb_taps  <= FEEDBACK_TAPS_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_FORWARD_TAPS:  r_fwd_taps <= i_cfg_data;
                REG_FEEDBACK_TAPS: r_fb_taps  <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_fhead     <= '0;
            r_bhead     <= '0;
            r_iss_d     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_fhead     <= n_fhead;
            r_bhead     <= n_bhead;
            r_iss_d     <= w_iss;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt   <= n_cnt;
        r_fh    <= n_fh;
        r_bh    <= n_bh;
        r_out   <= n_out;
        r_sel_d <= w_sel_fb;
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_fh        = r_fh;
        n_bh        = r_bh;
        n_fhead     = r_fhead;
        n_bhead     = r_bhead;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        w_iss       = 1'b0;
        w_sel_fb    = 1'b0;
        w_mac_clr   = 1'b0;
        w_hist_clr  = 1'b0;
        w_fc_we     = 1'b0;
        w_bc_we     = 1'b0;
        w_fi_we     = 1'b0;
        w_bo_we     = 1'b0;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (i_in_item.action)
                        ACT_SAMPLE: begin
                            w_fi_we   = 1'b1;
                            w_mac_clr = 1'b1;
                            n_fhead   = w_fhead_dec;
                            n_fh      = w_fhead_dec;
                            n_cnt     = '0;
                            n_state   = S_FWD;
                        end
                        ACT_LOAD_FWD: begin
                            w_fc_we = (8'(i_in_item.tap_index) < 8'(MAX_FORWARD_TAPS));
                        end
                        ACT_LOAD_FB: begin
                            w_bc_we = (8'(i_in_item.tap_index) < 8'(MAX_FEEDBACK_TAPS));
                        end
                        ACT_CLEAR: begin
                            w_hist_clr = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            S_FWD: begin
                w_iss = 1'b1;
                n_fh  = w_fh_inc;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == w_f_last) begin
                    n_cnt = '0;
                    if (w_fb_on) begin
                        n_bh    = r_bhead;
                        n_state = S_FB;
                    end else begin
                        n_state = S_DRAIN;
                    end
                end
            end
            S_FB: begin
                w_iss    = 1'b1;
                w_sel_fb = 1'b1;
                n_bh     = w_bh_inc;
                n_cnt    = r_cnt + 1'b1;
                if (r_cnt == w_b_last) begin
                    n_cnt   = '0;
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out       = w_round;
                    n_out_valid = 1'b1;
                    if (w_fb_on) begin
                        w_bo_we = 1'b1;
                        n_bhead = w_bhead_dec;
                    end
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    dfif_ram #(.DEPTH(MAX_FORWARD_TAPS)) u_fwd_coef (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clr   (1'b0),
        .i_we    (w_fc_we),
        .i_waddr (FA_W'(i_in_item.tap_index)),
        .i_wdata (i_in_item.coefficient),
        .i_raddr (FA_W'(r_cnt)),
        .o_rdata (w_fc_rd)
    );

    dfif_ram #(.DEPTH(MAX_FEEDBACK_TAPS)) u_fb_coef (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clr   (1'b0),
        .i_we    (w_bc_we),
        .i_waddr (BA_W'(i_in_item.tap_index)),
        .i_wdata (i_in_item.coefficient),
        .i_raddr (BA_W'(r_cnt)),
        .o_rdata (w_bc_rd)
    );

    dfif_ram #(.DEPTH(MAX_FORWARD_TAPS)) u_in_hist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clr   (w_hist_clr),
        .i_we    (w_fi_we),
        .i_waddr (w_fhead_dec),
        .i_wdata (i_in_item.sample_in),
        .i_raddr (r_fh),
        .o_rdata (w_fi_rd)
    );

    dfif_ram #(.DEPTH(MAX_FEEDBACK_TAPS)) u_out_hist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clr   (w_hist_clr),
        .i_we    (w_bo_we),
        .i_waddr (w_bhead_dec),
        .i_wdata (w_round.sample_out),
        .i_raddr (r_bh),
        .o_rdata (w_bo_rd)
    );

    dfif_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clr   (w_mac_clr),
        .i_valid (r_iss_d),
        .i_a     (r_sel_d ? w_bc_rd : w_fc_rd),
        .i_b     (r_sel_d ? w_bo_rd : w_fi_rd),
        .o_acc   (w_acc)
    );

    dfif_round u_round (
        .i_acc  (w_acc),
        .o_item (w_round)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

`ifndef SYNTHESIS
    a_fwd_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_FWD |-> r_cnt <= w_f_last)
        else $error("forward tap counter past taps in use");

    a_fb_only_with_taps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_FB |-> w_fb_on)
        else $error("feedback phase without feedback taps");

    a_sample_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && i_in_item.action == ACT_SAMPLE |=> !o_in_ready && !r_out_valid == !$past(n_out_valid))
        else $error("sample item did not start the tap walk");

    a_other_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && i_in_item.action != ACT_SAMPLE |=> o_in_ready)
        else $error("load or clear item held the block busy");
`endif

endmodule
